// File: hw/rtl/plrr_pkg.sv
// ----------------------------------------------------------------------------
// plrr_pkg
// Shared types and constants of the per-channel linear level remap block.
// ----------------------------------------------------------------------------
package plrr_pkg;

  // Pixel component and register geometry
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned RGB_W      = CHAN_W * NUM_CHAN;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = RGB_W;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_IN_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 8'd3;

  // Reset values of the registers
  localparam logic [RGB_W-1:0] RST_IN_LOW   = 24'h000000;
  localparam logic [RGB_W-1:0] RST_IN_HIGH  = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] RST_OUT_LOW  = 24'h000000;
  localparam logic [RGB_W-1:0] RST_OUT_HIGH = 24'hFFFFFF;

  // Arithmetic widths
  localparam int unsigned DIFF_W = CHAN_W + 1;      // signed difference of two channels
  localparam int unsigned PROD_W = 2 * DIFF_W;      // signed product
  localparam int unsigned NUM_W  = PROD_W + 1;      // signed numerator
  localparam int unsigned DVD_W  = 2 * CHAN_W + 1;  // 2*num + den
  localparam int unsigned DSR_W  = CHAN_W + 1;      // 2*den
  localparam int unsigned QUOT_W = CHAN_W;

  // Pipeline depth
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned DIV_STAGES   = QUOT_W;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // How a channel result is formed
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SAT,
    SEL_DIV
  } plrr_sel_e;

  // Configuration of one channel
  typedef struct packed {
    logic [CHAN_W-1:0] in_low;
    logic [CHAN_W-1:0] in_high;
    logic [CHAN_W-1:0] out_low;
    logic [CHAN_W-1:0] out_high;
  } plrr_chan_cfg_t;

  // All configuration registers
  typedef struct packed {
    logic [RGB_W-1:0] in_low;
    logic [RGB_W-1:0] in_high;
    logic [RGB_W-1:0] out_low;
    logic [RGB_W-1:0] out_high;
  } plrr_cfg_t;

  // Request from the mapping front end to the divider
  typedef struct packed {
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    plrr_sel_e        sel;
  } plrr_div_req_t;

  // Side data that travels beside the channel lanes
  typedef struct packed {
    logic [RGB_W-1:0]  raw_rgb;
    logic [CHAN_W-1:0] alpha;
    logic              empty;
  } plrr_side_t;

endpackage

// File: hw/rtl/plrr_ifs.sv
// ----------------------------------------------------------------------------
// plrr interfaces
// Valid/ready channels of the level remap block: pixel in, pixel out, config.
// ----------------------------------------------------------------------------
interface plrr_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [plrr_pkg::CHAN_W-1:0] red_in;
  logic [plrr_pkg::CHAN_W-1:0] green_in;
  logic [plrr_pkg::CHAN_W-1:0] blue_in;
  logic [plrr_pkg::CHAN_W-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface plrr_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [plrr_pkg::CHAN_W-1:0] red_out;
  logic [plrr_pkg::CHAN_W-1:0] green_out;
  logic [plrr_pkg::CHAN_W-1:0] blue_out;
  logic [plrr_pkg::CHAN_W-1:0] alpha_out;
  logic                        range_error;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, range_error,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, range_error,
                  output ready);
endinterface

interface plrr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [plrr_pkg::CFG_IDX_W-1:0]  index;
  logic [plrr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/plrr_cfg_regs.sv
// ----------------------------------------------------------------------------
// plrr_cfg_regs
// Range registers of the level remap block, written over the config channel.
// ----------------------------------------------------------------------------
module plrr_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  plrr_cfg_if.sink            cfg_i,
  output plrr_pkg::plrr_cfg_t regs_o
);

  plrr_pkg::plrr_cfg_t regs_q;
  plrr_pkg::plrr_cfg_t regs_d;

  // Always able to take a write
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        plrr_pkg::REG_IN_LOW:   regs_d.in_low   = cfg_i.data;
        plrr_pkg::REG_IN_HIGH:  regs_d.in_high  = cfg_i.data;
        plrr_pkg::REG_OUT_LOW:  regs_d.out_low  = cfg_i.data;
        plrr_pkg::REG_OUT_HIGH: regs_d.out_high = cfg_i.data;
        default:                regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.in_low   <= plrr_pkg::RST_IN_LOW;
      regs_q.in_high  <= plrr_pkg::RST_IN_HIGH;
      regs_q.out_low  <= plrr_pkg::RST_OUT_LOW;
      regs_q.out_high <= plrr_pkg::RST_OUT_HIGH;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

// File: hw/rtl/plrr_map_front.sv
// ----------------------------------------------------------------------------
// plrr_map_front
// Four-stage front end of one channel: differences, products, signed
// numerator, then clamp decision and divider operands.
// ----------------------------------------------------------------------------
module plrr_map_front (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [plrr_pkg::CHAN_W-1:0]   v_i,
  input  plrr_pkg::plrr_chan_cfg_t      ccfg_i,
  output plrr_pkg::plrr_div_req_t       req_o
);

  localparam int unsigned CW = plrr_pkg::CHAN_W;

  // Stage 1: differences
  logic signed [plrr_pkg::DIFF_W-1:0] dv_d, dv_q;
  logic signed [plrr_pkg::DIFF_W-1:0] dout_d, dout_q;
  logic signed [plrr_pkg::DIFF_W-1:0] den1_d, den1_q;
  logic signed [plrr_pkg::DIFF_W-1:0] ol1_d, ol1_q;
  // Stage 2: products
  logic signed [plrr_pkg::PROD_W-1:0] p1_d, p1_q;
  logic signed [plrr_pkg::PROD_W-1:0] p2_d, p2_q;
  logic signed [plrr_pkg::DIFF_W-1:0] den2_q;
  // Stage 3: numerator with positive denominator
  logic signed [plrr_pkg::NUM_W-1:0]  sum;
  logic signed [plrr_pkg::NUM_W-1:0]  num_d, num_q;
  logic [CW-1:0]                      dena_d, dena_q;
  // Stage 4: clamp decision
  logic [2*CW-1:0]                    sat_lim;
  plrr_pkg::plrr_div_req_t            req_d, req_q;

  assign dv_d   = $signed({1'b0, v_i}) - $signed({1'b0, ccfg_i.in_low});
  assign dout_d = $signed({1'b0, ccfg_i.out_high}) - $signed({1'b0, ccfg_i.out_low});
  assign den1_d = $signed({1'b0, ccfg_i.in_high}) - $signed({1'b0, ccfg_i.in_low});
  assign ol1_d  = $signed({1'b0, ccfg_i.out_low});

  assign p1_d = dv_q * dout_q;
  assign p2_d = ol1_q * den1_q;

  // Flip signs so the denominator is positive
  always_comb begin
    sum = plrr_pkg::NUM_W'(p1_q) + plrr_pkg::NUM_W'(p2_q);
    if (den2_q[plrr_pkg::DIFF_W-1]) begin
      num_d  = -sum;
      dena_d = CW'(-den2_q);
    end else begin
      num_d  = sum;
      dena_d = den2_q[CW-1:0];
    end
  end

  // 255*den limit, then pick zero, saturate or divide
  assign sat_lim = {dena_q, {CW{1'b0}}} - {{CW{1'b0}}, dena_q};

  always_comb begin
    req_d.dividend = {num_q[2*CW-1:0], 1'b0} + plrr_pkg::DVD_W'(dena_q);
    req_d.divisor  = {dena_q, 1'b0};
    if (num_q <= 0) begin
      req_d.sel = plrr_pkg::SEL_ZERO;
    end else if (num_q >= $signed({{(plrr_pkg::NUM_W-2*CW){1'b0}}, sat_lim})) begin
      req_d.sel = plrr_pkg::SEL_SAT;
    end else begin
      req_d.sel = plrr_pkg::SEL_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q   <= dv_d;
      dout_q <= dout_d;
      den1_q <= den1_d;
      ol1_q  <= ol1_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      den2_q <= den1_q;
      num_q  <= num_d;
      dena_q <= dena_d;
      req_q  <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

// File: hw/rtl/plrr_div_pipe.sv
// ----------------------------------------------------------------------------
// plrr_div_pipe
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Resolves the clamp selection into the final channel value.
// ----------------------------------------------------------------------------
module plrr_div_pipe (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  plrr_pkg::plrr_div_req_t      req_i,
  output logic [plrr_pkg::CHAN_W-1:0]  result_o
);

  localparam int unsigned RW = plrr_pkg::DVD_W;
  localparam int unsigned NS = plrr_pkg::DIV_STAGES;

  logic [RW-1:0]                  rem_q [NS];
  logic [plrr_pkg::QUOT_W-1:0]    quo_q [NS];
  logic [plrr_pkg::DSR_W-1:0]     dsr_q [NS];
  plrr_pkg::plrr_sel_e            sel_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int unsigned SH = plrr_pkg::QUOT_W - 1 - k;

    logic [RW-1:0]               rem_in;
    logic [plrr_pkg::QUOT_W-1:0] quo_in;
    logic [plrr_pkg::DSR_W-1:0]  dsr_in;
    plrr_pkg::plrr_sel_e         sel_in;
    logic [RW:0]                 shd;
    logic [RW:0]                 trial;
    logic [RW-1:0]               rem_d;
    logic [plrr_pkg::QUOT_W-1:0] quo_d;

    // Stage input: request or previous stage
    if (k == 0) begin : g_first
      assign rem_in = req_i.dividend;
      assign quo_in = '0;
      assign dsr_in = req_i.divisor;
      assign sel_in = req_i.sel;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign sel_in = sel_q[k-1];
    end

    // Trial subtract of the shifted divisor
    always_comb begin
      shd   = (RW+1)'(dsr_in) << SH;
      trial = {1'b0, rem_in} - shd;
      rem_d = rem_in;
      quo_d = quo_in;
      if (!trial[RW]) begin
        rem_d      = trial[RW-1:0];
        quo_d[SH]  = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        dsr_q[k] <= dsr_in;
        sel_q[k] <= sel_in;
      end
    end
  end

  // Final channel value
  always_comb begin
    case (sel_q[NS-1])
      plrr_pkg::SEL_ZERO: result_o = '0;
      plrr_pkg::SEL_SAT:  result_o = plrr_pkg::CHAN_MAX;
      plrr_pkg::SEL_DIV:  result_o = quo_q[NS-1];
      default:            result_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/pixel_linear_level_remap.sv
// ----------------------------------------------------------------------------
// pixel_linear_level_remap
// Per-channel linear level remap of an RGBA pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i  : valid/ready pixel input (red, green, blue, alpha), one transfer
//            per clock when the output side is not stalled.
//   pix_o  : valid/ready pixel output with remapped RGB, alpha copied and a
//            range_error flag set when any channel has an empty input range
//            (then the pixel passes unchanged).
//   cfg_i  : valid/ready register write (index, 24-bit data); always ready.
//            Write only while no pixel is in flight.
// From input transfer to output valid the path has 4 front stages
// (differences, products, numerator, clamp decision), 8 divider stages
// (one quotient bit each) and the output register. Throughput is one pixel
// per cycle, set by the single-bit-per-stage divider pipeline, unless stalled.
// Reset clears all valid bits and loads the default ranges (identity map).
// When the receiver stalls with a result waiting, the whole pipeline holds;
// input ready follows output ready in that case, and nothing is lost.
// ----------------------------------------------------------------------------
module pixel_linear_level_remap (
  input  logic          clk_i,
  input  logic          rst_ni,
  plrr_pix_in_if.sink   pix_i,
  plrr_pix_out_if.source pix_o,
  plrr_cfg_if.sink      cfg_i
);

  localparam int unsigned CW = plrr_pkg::CHAN_W;
  localparam int unsigned ND = plrr_pkg::PIPE_DEPTH;

  plrr_pkg::plrr_cfg_t       regs;
  plrr_pkg::plrr_chan_cfg_t  ccfg [plrr_pkg::NUM_CHAN];
  logic [CW-1:0]             chan_in  [plrr_pkg::NUM_CHAN];
  logic [CW-1:0]             chan_res [plrr_pkg::NUM_CHAN];
  plrr_pkg::plrr_div_req_t   req [plrr_pkg::NUM_CHAN];

  logic                      adv;
  logic                      empty;
  logic                      vld_q  [ND];
  plrr_pkg::plrr_side_t      side_q [ND];
  plrr_pkg::plrr_side_t      side_d;

  logic                      out_vld_q;
  logic [plrr_pkg::RGB_W-1:0] out_rgb_q, out_rgb_d;
  logic [CW-1:0]             out_alpha_q;
  logic                      out_err_q;

  // Configuration registers
  plrr_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Pipeline moves whenever the output register is free or being taken
  assign adv         = !out_vld_q || pix_o.ready;
  assign pix_i.ready = adv;

  assign chan_in[0] = pix_i.red_in;
  assign chan_in[1] = pix_i.green_in;
  assign chan_in[2] = pix_i.blue_in;

  // Per-channel lanes
  for (genvar c = 0; c < plrr_pkg::NUM_CHAN; c++) begin : g_lane
    assign ccfg[c].in_low   = regs.in_low[c*CW +: CW];
    assign ccfg[c].in_high  = regs.in_high[c*CW +: CW];
    assign ccfg[c].out_low  = regs.out_low[c*CW +: CW];
    assign ccfg[c].out_high = regs.out_high[c*CW +: CW];

    plrr_map_front u_front (
      .clk_i  (clk_i),
      .en_i   (adv),
      .v_i    (chan_in[c]),
      .ccfg_i (ccfg[c]),
      .req_o  (req[c])
    );

    plrr_div_pipe u_div (
      .clk_i    (clk_i),
      .en_i     (adv),
      .req_i    (req[c]),
      .result_o (chan_res[c])
    );
  end

  // Empty input range on any channel
  assign empty = (ccfg[0].in_low == ccfg[0].in_high) ||
                 (ccfg[1].in_low == ccfg[1].in_high) ||
                 (ccfg[2].in_low == ccfg[2].in_high);

  always_comb begin
    side_d.raw_rgb = {pix_i.blue_in, pix_i.green_in, pix_i.red_in};
    side_d.alpha   = pix_i.alpha_in;
    side_d.empty   = empty;
  end

  // Valid bits beside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ND; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= pix_i.valid;
      for (int i = 1; i < ND; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Side payload beside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < ND; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Pass-through on empty range, else lane results
  assign out_rgb_d = side_q[ND-1].empty ? side_q[ND-1].raw_rgb
                                        : {chan_res[2], chan_res[1], chan_res[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[ND-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rgb_q   <= out_rgb_d;
      out_alpha_q <= side_q[ND-1].alpha;
      out_err_q   <= side_q[ND-1].empty;
    end
  end

  assign pix_o.valid       = out_vld_q;
  assign pix_o.red_out     = out_rgb_q[0*CW +: CW];
  assign pix_o.green_out   = out_rgb_q[1*CW +: CW];
  assign pix_o.blue_out    = out_rgb_q[2*CW +: CW];
  assign pix_o.alpha_out   = out_alpha_q;
  assign pix_o.range_error = out_err_q;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_linear_level_remap. A directed table covers
// the identity map, empty input ranges, reversed ranges, flat outputs,
// clamping and half-up rounding. Random phases with fresh register settings
// follow. Every pixel transfer is predicted by the table or by an exact
// integer remap and compared with the result stream, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import plrr_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_PHASES   = 10;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              range_err;
  } remap_result_t;

  // One row of the directed table; want is only used when typed_exp is set
  typedef struct packed {
    plrr_cfg_t     cfg;
    pixel_t        pix;
    logic          typed_exp;
    remap_result_t want;
  } directed_row_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  // Register settings used by the directed table (in_low, in_high, out_low, out_high)
  localparam plrr_cfg_t CFG_IDENT      = '{RST_IN_LOW, RST_IN_HIGH, RST_OUT_LOW, RST_OUT_HIGH};
  localparam plrr_cfg_t CFG_RED_EMPTY  = '{24'h000000, 24'hFFFF00, 24'h000000, 24'hFFFFFF};
  localparam plrr_cfg_t CFG_BLUE_EMPTY = '{24'h000000, 24'h00FFFF, 24'h000000, 24'hFFFFFF};
  localparam plrr_cfg_t CFG_ALL_EMPTY  = '{24'h373737, 24'h373737, 24'h102030, 24'hC0B0A0};
  localparam plrr_cfg_t CFG_INV_IN     = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF};
  localparam plrr_cfg_t CFG_INV_OUT    = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
  localparam plrr_cfg_t CFG_FLAT_MID   = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h808080};
  localparam plrr_cfg_t CFG_CLAMP      = '{24'h404040, 24'hC0C0C0, 24'h000000, 24'hFFFFFF};
  localparam plrr_cfg_t CFG_HALF       = '{24'h000000, 24'h020202, 24'h000000, 24'h010101};
  localparam plrr_cfg_t CFG_MIXED      = '{24'h102030, 24'hE0D0C0, 24'h051525, 24'hFAEADA};
  localparam plrr_cfg_t CFG_CROSSED    = '{24'h00FF10, 24'hFF00F0, 24'hFF0020, 24'h00FFE0};
  localparam plrr_cfg_t CFG_FLAT_MAX   = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
  localparam plrr_cfg_t CFG_FLAT_MIN   = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000};
  localparam plrr_cfg_t CFG_STEP       = '{24'h000000, 24'h010101, 24'h000000, 24'hFFFFFF};

  localparam int NUM_DIRECTED = 22;
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // identity after reset
    '{CFG_IDENT, '{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
    '{CFG_IDENT, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
    '{CFG_IDENT, '{8'h5A, 8'hA5, 8'h0F, 8'hF0}, 1'b1, '{8'h5A, 8'hA5, 8'h0F, 8'hF0, 1'b0}},
    '{CFG_IDENT, '{8'h01, 8'h80, 8'h7F, 8'hFE}, 1'b1, '{8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0}},
    // empty input range on one channel or all: pass through, flag set
    '{CFG_RED_EMPTY, '{8'h12, 8'h34, 8'h56, 8'h78}, 1'b1, '{8'h12, 8'h34, 8'h56, 8'h78, 1'b1}},
    '{CFG_BLUE_EMPTY, '{8'h80, 8'h7F, 8'h01, 8'hAB}, 1'b1, '{8'h80, 8'h7F, 8'h01, 8'hAB, 1'b1}},
    '{CFG_ALL_EMPTY, '{8'hFF, 8'h00, 8'h37, 8'h00}, 1'b1, '{8'hFF, 8'h00, 8'h37, 8'h00, 1'b1}},
    // reversed input range, then reversed output range
    '{CFG_INV_IN, '{8'h00, 8'hFF, 8'h40, 8'h11}, 1'b1, '{8'hFF, 8'h00, 8'hBF, 8'h11, 1'b0}},
    '{CFG_INV_OUT, '{8'h01, 8'hFE, 8'h80, 8'h22}, 1'b1, '{8'hFE, 8'h01, 8'h7F, 8'h22, 1'b0}},
    // flat output range
    '{CFG_FLAT_MID, '{8'h00, 8'hFF, 8'h33, 8'h44}, 1'b1, '{8'h80, 8'h80, 8'h80, 8'h44, 1'b0}},
    // values outside the input range clamp; midpoint lands on a half
    '{CFG_CLAMP, '{8'h00, 8'hFF, 8'h80, 8'h55}, 1'b1, '{8'h00, 8'hFF, 8'h80, 8'h55, 1'b0}},
    '{CFG_CLAMP, '{8'h41, 8'hBF, 8'h3F, 8'hAA}, 1'b0, '0},
    // exact half rounds up
    '{CFG_HALF, '{8'h01, 8'h00, 8'h02, 8'h66}, 1'b1, '{8'h01, 8'h00, 8'h01, 8'h66, 1'b0}},
    '{CFG_HALF, '{8'hFF, 8'h03, 8'h80, 8'h00}, 1'b0, '0},
    '{CFG_MIXED, '{8'h7F, 8'h80, 8'h81, 8'hC3}, 1'b0, '0},
    '{CFG_CROSSED, '{8'h00, 8'hFF, 8'h10, 8'h01}, 1'b0, '0},
    '{CFG_CROSSED, '{8'hFF, 8'h00, 8'hF0, 8'hFE}, 1'b0, '0},
    '{CFG_FLAT_MAX, '{8'h12, 8'h34, 8'h56, 8'h78}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h78, 1'b0}},
    '{CFG_FLAT_MIN, '{8'hAB, 8'hCD, 8'hEF, 8'h01}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 1'b0}},
    // input span of one: a unit step to full scale
    '{CFG_STEP, '{8'h00, 8'h01, 8'hFF, 8'h80}, 1'b1, '{8'h00, 8'hFF, 8'hFF, 8'h80, 1'b0}},
    '{CFG_STEP, '{8'h01, 8'h00, 8'h02, 8'h7F}, 1'b0, '0},
    '{CFG_IDENT, '{8'h5A, 8'hC3, 8'h3C, 8'h99}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  plrr_pix_in_if  pix_in_bus();
  plrr_pix_out_if pix_out_bus();
  plrr_cfg_if     cfg_bus();

  pixel_linear_level_remap DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in_bus),
    .pix_o  (pix_out_bus),
    .cfg_i  (cfg_bus)
  );

  plrr_cfg_t     cfg_model = CFG_IDENT;
  remap_result_t pending_pixels[$];
  int            mismatch_count = 0;
  int            burst_left = 1;
  rx_mode_e      rx_mode = RX_STEADY;
  int            rx_left = 0;
  int            rx_tick = 0;

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Exact remap of one channel: clamp at both ends, otherwise round half up
  function automatic logic [CHAN_W-1:0] stretch_level(
    input logic [CHAN_W-1:0] v,
    input logic [CHAN_W-1:0] il,
    input logic [CHAN_W-1:0] ih,
    input logic [CHAN_W-1:0] ol,
    input logic [CHAN_W-1:0] oh
  );
    int span;
    int num;
    span = int'(ih) - int'(il);
    num  = (int'(v) - int'(il)) * (int'(oh) - int'(ol)) + int'(ol) * span;
    if (span < 0) begin
      span = -span;
      num  = -num;
    end
    if (num <= 0) return '0;
    if (num >= int'(CHAN_MAX) * span) return CHAN_MAX;
    return CHAN_W'((2 * num + span) / (2 * span));
  endfunction

  // Expected result of one pixel under the given registers
  function automatic remap_result_t remap_pixel(input pixel_t px, input plrr_cfg_t cfg);
    logic [CHAN_W-1:0] chan_in [NUM_CHAN];
    logic [CHAN_W-1:0] chan_out [NUM_CHAN];
    logic              empty;
    chan_in = '{px.red, px.green, px.blue};
    empty = 1'b0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (cfg.in_low[CHAN_W*k +: CHAN_W] == cfg.in_high[CHAN_W*k +: CHAN_W]) empty = 1'b1;
    end
    for (int k = 0; k < NUM_CHAN; k++) begin
      chan_out[k] = empty ? chan_in[k] :
                    stretch_level(chan_in[k],
                                  cfg.in_low[CHAN_W*k +: CHAN_W],
                                  cfg.in_high[CHAN_W*k +: CHAN_W],
                                  cfg.out_low[CHAN_W*k +: CHAN_W],
                                  cfg.out_high[CHAN_W*k +: CHAN_W]);
    end
    return '{chan_out[0], chan_out[1], chan_out[2], px.alpha, empty};
  endfunction

  // Level biased toward the ends of the range
  function automatic logic [CHAN_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CHAN_MAX;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random register set: mostly non-empty ranges, some narrow, some reversed
  function automatic plrr_cfg_t random_config();
    plrr_cfg_t         cfg;
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] hi;
    for (int k = 0; k < NUM_CHAN; k++) begin
      lo = pick_level();
      hi = pick_level();
      if ($urandom_range(0, 3) == 0) begin
        hi = lo + CHAN_W'($urandom_range(1, 4));
      end else if (lo == hi && $urandom_range(0, 3) != 0) begin
        hi = ~lo;
      end
      cfg.in_low[CHAN_W*k +: CHAN_W]   = lo;
      cfg.in_high[CHAN_W*k +: CHAN_W]  = hi;
      cfg.out_low[CHAN_W*k +: CHAN_W]  = pick_level();
      cfg.out_high[CHAN_W*k +: CHAN_W] = pick_level();
    end
    return cfg;
  endfunction

  // Mostly uniform channel values, with the extremes now and then
  function automatic logic [CHAN_W-1:0] random_channel();
    if ($urandom_range(0, 3) == 0) return pick_level();
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // Drive one pixel until transferred, queue its expectation, then maybe idle
  task automatic send_pixel(input pixel_t px, input remap_result_t want);
    int gap;
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.red_in   <= px.red;
    pix_in_bus.green_in <= px.green;
    pix_in_bus.blue_in  <= px.blue;
    pix_in_bus.alpha_in <= px.alpha;
    @(posedge clk_i);
    while (!pix_in_bus.ready) @(posedge clk_i);
    pending_pixels.push_back(want);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        pix_in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending, wait for every queued result, then let the pipeline settle
  task automatic wait_drained();
    pix_in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // One register write transfer; leaves valid high for a following write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_IN_LOW:   cfg_model.in_low   = value;
      REG_IN_HIGH:  cfg_model.in_high  = value;
      REG_OUT_LOW:  cfg_model.out_low  = value;
      REG_OUT_HIGH: cfg_model.out_high = value;
      default: ;
    endcase
  endtask

  // Load a full register set in shuffled order, sometimes with a stray index
  task automatic apply_config(input plrr_cfg_t cfg);
    logic [CFG_IDX_W-1:0] order [4];
    logic [CFG_IDX_W-1:0] held;
    int                   j;
    wait_drained();
    order = '{REG_IN_LOW, REG_IN_HIGH, REG_OUT_LOW, REG_OUT_HIGH};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      held = order[i];
      order[i] = order[j];
      order[j] = held;
    end
    if ($urandom_range(0, 1) == 1) begin
      write_register(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    end
    for (int i = 0; i < 4; i++) begin
      case (order[i])
        REG_IN_LOW:   write_register(order[i], cfg.in_low);
        REG_IN_HIGH:  write_register(order[i], cfg.in_high);
        REG_OUT_LOW:  write_register(order[i], cfg.out_low);
        default:      write_register(order[i], cfg.out_high);
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Receiver: switches between stall patterns at random intervals
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_STEADY: pix_out_bus.ready <= 1'b1;
      RX_COIN:   pix_out_bus.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: pix_out_bus.ready <= ($urandom_range(0, 7) != 0);
      default:   pix_out_bus.ready <= ((rx_tick % 7) < 3);
    endcase
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    remap_result_t got;
    remap_result_t want;
    if (rst_ni && pix_out_bus.valid && pix_out_bus.ready) begin
      got = '{pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out,
              pix_out_bus.alpha_out, pix_out_bus.range_error};
      if (pending_pixels.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result: r=%02h g=%02h b=%02h a=%02h err=%0b",
                   got.red, got.green, got.blue, got.alpha, got.range_err);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.range_err !== want.range_err) begin
          if (mismatch_count < MAX_REPORTS) begin
            $write("mismatch: expected r=%02h g=%02h b=%02h a=%02h err=%0b, ",
                   want.red, want.green, want.blue, want.alpha, want.range_err);
            $display("got r=%02h g=%02h b=%02h a=%02h err=%0b",
                     got.red, got.green, got.blue, got.alpha, got.range_err);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    pixel_t px;
    int     count;
    rst_ni               = 1'b0;
    pix_in_bus.valid     = 1'b0;
    pix_in_bus.red_in    = '0;
    pix_in_bus.green_in  = '0;
    pix_in_bus.blue_in   = '0;
    pix_in_bus.alpha_in  = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].cfg != cfg_model) apply_config(DIRECTED_ROWS[r].cfg);
      send_pixel(DIRECTED_ROWS[r].pix,
                 DIRECTED_ROWS[r].typed_exp ? DIRECTED_ROWS[r].want :
                                              remap_pixel(DIRECTED_ROWS[r].pix, cfg_model));
    end

    // Random phases, each under a fresh register set
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      apply_config(random_config());
      count = $urandom_range(70, 90);
      for (int n = 0; n < count; n++) begin
        px = '{random_channel(), random_channel(), random_channel(),
               CHAN_W'($urandom_range(0, 255))};
        send_pixel(px, remap_pixel(px, cfg_model));
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/plrr_pkg.sv
hw/rtl/plrr_ifs.sv
hw/rtl/plrr_cfg_regs.sv
hw/rtl/plrr_map_front.sv
hw/rtl/plrr_div_pipe.sv
hw/rtl/pixel_linear_level_remap.sv
dv/testbench.sv
